// File: rtl/aed_pkg.sv
// ----------------------------------------------------------------------------
// aed_pkg
// Shared types and constants for the all-pass echo delay block.
// ----------------------------------------------------------------------------
package aed_pkg;

  localparam int DELAY_DEPTH_DEF = 16384;
  localparam int FRACTION_BITS   = 12;
  localparam int SAMPLE_W        = 16;
  localparam int LEN_W           = 14;
  localparam int COEF_W          = 16;
  localparam int GAIN_ONE        = 32768;

  localparam int LEN_RESET    = 15000;
  localparam int GAIN_RESET   = 29491;
  localparam int VOL_RESET    = 32768;
  localparam int OFFSET_RESET = (18 * (1 << FRACTION_BITS) + 5) / 10;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_DELAY_LENGTH,
    REG_FEEDBACK_GAIN,
    REG_VOLUME,
    REG_OUTPUT_OFFSET
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GG,
    ST_GD,
    ST_GX,
    ST_CF,
    ST_ACC,
    ST_VL,
    ST_VH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]           delay_length;
    logic [COEF_W-1:0]          feedback_gain;
    logic [COEF_W-1:0]          volume;
    logic signed [SAMPLE_W-1:0] output_offset;
  } cfg_t;

  typedef struct packed {
    logic   load_in;
    state_t step;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: rtl/aed_if.sv
// ----------------------------------------------------------------------------
// aed_if
// Valid/ready stream interfaces for input and output samples.
// ----------------------------------------------------------------------------
interface aed_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [aed_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface aed_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [aed_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// File: rtl/aed_ram.sv
// ----------------------------------------------------------------------------
// aed_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module aed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/aed_regs.sv
// ----------------------------------------------------------------------------
// aed_regs
// APB configuration registers: delay length, feedback gain, volume, offset.
// ----------------------------------------------------------------------------
module aed_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aed_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [aed_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [aed_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output aed_pkg::cfg_t                   cfg
);
  import aed_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_length  <= LEN_W'(LEN_RESET);
      cfg.feedback_gain <= COEF_W'(GAIN_RESET);
      cfg.volume        <= COEF_W'(VOL_RESET);
      cfg.output_offset <= SAMPLE_W'(OFFSET_RESET);
    end else if (wr_en) begin
      case (idx)
        REG_DELAY_LENGTH:  cfg.delay_length  <= pwdata[LEN_W-1:0];
        REG_FEEDBACK_GAIN: cfg.feedback_gain <= pwdata[COEF_W-1:0];
        REG_VOLUME:        cfg.volume        <= pwdata[COEF_W-1:0];
        REG_OUTPUT_OFFSET: cfg.output_offset <= $signed(pwdata[SAMPLE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELAY_LENGTH:  prdata = APB_DATA_W'(cfg.delay_length);
      REG_FEEDBACK_GAIN: prdata = APB_DATA_W'(cfg.feedback_gain);
      REG_VOLUME:        prdata = APB_DATA_W'(cfg.volume);
      REG_OUTPUT_OFFSET: prdata = APB_DATA_W'($unsigned(cfg.output_offset));
      default:           prdata = '0;
    endcase
  end

endmodule

// File: rtl/aed_ctrl.sv
// ----------------------------------------------------------------------------
// aed_ctrl
// Sequencer: steps one sample through read, multiply, write-back and output.
// ----------------------------------------------------------------------------
module aed_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output aed_pkg::cmd_t    cmd,
  input  aed_pkg::status_t status
);
  import aed_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.load_out = 1'b0;
    cmd.step     = state;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_in = 1'b1;
          state_next  = ST_GG;
        end
      end
      ST_GG:  state_next = ST_GD;
      ST_GD:  state_next = ST_GX;
      ST_GX:  state_next = ST_CF;
      ST_CF:  state_next = ST_ACC;
      ST_ACC: state_next = ST_VL;
      ST_VL:  state_next = ST_VH;
      ST_VH:  state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/aed_dp.sv
// ----------------------------------------------------------------------------
// aed_dp
// Datapath: delay store, shared 18x18 multiplier, accumulator, output register.
// ----------------------------------------------------------------------------
module aed_dp #(
  parameter int DEPTH = aed_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  aed_pkg::cfg_t                       cfg,
  input  aed_pkg::cmd_t                       cmd,
  output aed_pkg::status_t                    status,
  input  logic signed [aed_pkg::SAMPLE_W-1:0] sample_in,
  output logic signed [aed_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                out_valid,
  input  logic                                out_ready
);
  import aed_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = PTR_W + 1;
  localparam int LW     = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 34;
  localparam int HALF_W = 17;
  localparam int TOT_W  = 50;
  localparam int G_W    = COEF_W + 1;

  localparam logic signed [PROD_W-1:0] HALF15 = PROD_W'(1 << 14);
  localparam logic signed [TOT_W-1:0]  HALF30 = TOT_W'(1 << 29);
  localparam logic signed [TOT_W-1:0]  S_MAX  = TOT_W'(32767);
  localparam logic signed [TOT_W-1:0]  S_MIN  = TOT_W'(-32768);

  logic [PTR_W-1:0]           ptr;
  logic [FILL_W-1:0]          fill;
  logic signed [SAMPLE_W-1:0] x;
  logic                       d_ok;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   lo_prod;
  logic [G_W-1:0]             c;
  logic signed [SAMPLE_W-1:0] fb;
  logic signed [ACC_W-1:0]    acc;

  logic [SAMPLE_W-1:0]        rd_data;
  logic [SAMPLE_W-1:0]        wr_data;
  logic signed [SAMPLE_W-1:0] d_eff;
  logic [G_W-1:0]             g;
  logic [G_W-1:0]             vol;
  logic [LW-1:0]              len_raw;
  logic [LW-1:0]              len_c;
  logic [LW-1:0]              ptr_inc;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic                       mul_en;
  logic signed [PROD_W-1:0]   prod_q15;
  logic signed [SAMPLE_W:0]   fbx;
  logic signed [ACC_W-1:0]    prod_acc;
  logic signed [TOT_W-1:0]    hi_ext;
  logic signed [TOT_W-1:0]    lo_ext;
  logic signed [TOT_W-1:0]    tot_q;
  logic signed [SAMPLE_W-1:0] result;

  aed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (cmd.step == ST_CF),
    .waddr (ptr),
    .wdata (wr_data),
    .re    (cmd.load_in),
    .raddr (ptr),
    .rdata (rd_data)
  );

  assign g   = (cfg.feedback_gain > COEF_W'(GAIN_ONE - 1)) ? G_W'(GAIN_ONE)
                                                          : {1'b0, cfg.feedback_gain};
  assign vol = (cfg.volume > COEF_W'(GAIN_ONE - 1)) ? G_W'(GAIN_ONE) : {1'b0, cfg.volume};

  always_comb begin
    len_raw = LW'(cfg.delay_length);
    if (len_raw == '0) begin
      len_c = LW'(1);
    end else if (len_raw > LW'(DEPTH)) begin
      len_c = LW'(DEPTH);
    end else begin
      len_c = len_raw;
    end
  end

  assign ptr_inc  = LW'(ptr) + LW'(1);
  assign d_eff    = d_ok ? $signed(rd_data) : '0;
  assign prod_q15 = (prod + HALF15) >>> 15;
  assign fbx      = $signed({fb[SAMPLE_W-1], fb}) + $signed({x[SAMPLE_W-1], x});
  assign wr_data  = (fbx[SAMPLE_W] != fbx[SAMPLE_W-1])
                    ? {fbx[SAMPLE_W], {(SAMPLE_W-1){~fbx[SAMPLE_W]}}}
                    : fbx[SAMPLE_W-1:0];
  assign prod_acc = $signed(prod[ACC_W-1:0]);

  assign hi_ext = {{(TOT_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign lo_ext = {{(TOT_W-PROD_W){lo_prod[PROD_W-1]}}, lo_prod};
  assign tot_q  = ((hi_ext <<< HALF_W) + lo_ext + HALF30) >>> 30;

  always_comb begin
    if (tot_q > S_MAX) begin
      result = SAMPLE_W'(S_MAX);
    end else if (tot_q < S_MIN) begin
      result = SAMPLE_W'(S_MIN);
    end else begin
      result = tot_q[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.step)
      ST_GG: begin
        mul_a = $signed({1'b0, g});
        mul_b = $signed({1'b0, g});
      end
      ST_GD: begin
        mul_a = $signed({1'b0, g});
        mul_b = MUL_W'(d_eff);
      end
      ST_GX: begin
        mul_a = $signed({1'b0, g});
        mul_b = MUL_W'(x);
      end
      ST_CF: begin
        mul_a = $signed({1'b0, c});
        mul_b = MUL_W'(fb);
      end
      ST_VL: begin
        mul_a = $signed({1'b0, vol});
        mul_b = $signed({1'b0, acc[HALF_W-1:0]});
      end
      ST_VH: begin
        mul_a = $signed({1'b0, vol});
        mul_b = $signed({acc[ACC_W-1], acc[ACC_W-1:HALF_W]});
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.step)
      ST_GD:   c       <= G_W'(GAIN_ONE) - prod_q15[G_W-1:0];
      ST_GX:   fb      <= prod_q15[SAMPLE_W-1:0];
      ST_CF:   acc     <= $signed({{(ACC_W-SAMPLE_W-15){cfg.output_offset[SAMPLE_W-1]}},
                                   cfg.output_offset, 15'b0}) - prod_acc;
      ST_ACC:  acc     <= acc + prod_acc;
      ST_VH:   lo_prod <= prod;
      default: ;
    endcase
    if (cmd.load_in) begin
      x <= sample_in;
    end
    if (cmd.load_out) begin
      sample_out <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      fill      <= '0;
      d_ok      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        d_ok <= ({1'b0, ptr} < fill);
      end
      if (cmd.step == ST_CF) begin
        ptr <= (ptr_inc >= len_c) ? '0 : ptr_inc[PTR_W-1:0];
        if (ptr_inc > LW'(fill)) begin
          fill <= ptr_inc[FILL_W-1:0];
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

// File: rtl/allpass_echo_delay.sv
// ----------------------------------------------------------------------------
// allpass_echo_delay
// All-pass echo on a circular delay line with volume, offset and saturation.
//
// Input samples arrive on the upstream valid/ready channel, results leave on
// the downstream channel, one result per sample, in order. Registers must be
// written over the APB port only while no sample is in flight; the block
// itself does not enforce this. A sample is taken only when the sequencer is
// idle, and the next sample can be taken in the cycle after the result is
// loaded into the output register. The six products of a sample share one
// 18x18 multiplier, each in its own sequencer step.
// The output register holds a result while downstream stalls; a new sample
// is still accepted and worked on, and waits in its last step until the
// register is free.
// Reset loads the register defaults and empties the delay line: a fill count
// marks entries never written, which read as zero, so no clearing pass runs
// and the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module allpass_echo_delay #(
  parameter int DELAY_DEPTH = aed_pkg::DELAY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  aed_in_if.sink                         upstream,
  aed_out_if.source                      downstream,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aed_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [aed_pkg::APB_DATA_W-1:0] pwdata,
  output logic [aed_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import aed_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  aed_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (upstream.valid),
    .in_ready (upstream.ready),
    .cmd      (cmd),
    .status   (status)
  );

  aed_dp #(
    .DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .sample_in  (upstream.sample_in),
    .sample_out (downstream.sample_out),
    .out_valid  (downstream.valid),
    .out_ready  (downstream.ready)
  );

endmodule
